FILE: hw/rtl/clipped_line_rasterizer_assert.svh
// Assertion macros for the line rasterizer.
// Each macro expects clk and rst_n in scope.
`ifndef CLIPPED_LINE_RASTERIZER_ASSERT_SVH
`define CLIPPED_LINE_RASTERIZER_ASSERT_SVH

// Check that cond holds in the same cycle as trig
`define CLR_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig
`define CLR_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/clr_pkg.sv
package clr_pkg;

  localparam int COORD_W = 6;
  localparam int CLIP_W  = 7;
  localparam int STYLE_W = 8;
  localparam int GLYPH_W = 2;
  localparam int ERR_W   = COORD_W + 3;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Largest coordinate plus one; inputs above COORD_MAX saturate to COORD_MAX
  localparam logic [COORD_W:0] COORD_LIMIT = 7'd64;
  localparam logic [COORD_W:0] COORD_MAX   = COORD_LIMIT - 7'd1;

  localparam logic [CLIP_W-1:0] CLIP_RESET = 7'd64;

  // Register indexes (word address bit)
  localparam logic REG_CLIP_WIDTH  = 1'b0;
  localparam logic REG_CLIP_HEIGHT = 1'b1;

  // Slope glyph codes
  localparam logic [GLYPH_W-1:0] GLYPH_DASH  = 2'd0;
  localparam logic [GLYPH_W-1:0] GLYPH_BAR   = 2'd1;
  localparam logic [GLYPH_W-1:0] GLYPH_BACK  = 2'd2;
  localparam logic [GLYPH_W-1:0] GLYPH_SLASH = 2'd3;

  // Clamp a coordinate to the coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W:0] wide;
    wide = {1'b0, v};
    if (wide > COORD_MAX) begin
      return COORD_MAX[COORD_W-1:0];
    end
    return v;
  endfunction

  // Absolute difference of two coordinates
  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    if (a > b) begin
      return a - b;
    end
    return b - a;
  endfunction

endpackage

FILE: hw/rtl/clipped_line_rasterizer.sv
// Line rasterizer: one segment in, max(|dx|,|dy|)+1 cells out.
// The segment is registered, S_SETUP forms the initial error, S_WALK emits cells
// via the output register: one cell per cycle while out_ready is high, set by
// the single shared error adder. A new segment is taken only in S_IDLE.
// Reset (rst_n low, synchronous): sequencer idle, output empty, both clip
// registers set to 64.
module clipped_line_rasterizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [clr_pkg::COORD_W-1:0]   in_start_x,
  input  logic [clr_pkg::COORD_W-1:0]   in_start_y,
  input  logic [clr_pkg::COORD_W-1:0]   in_end_x,
  input  logic [clr_pkg::COORD_W-1:0]   in_end_y,
  input  logic [clr_pkg::STYLE_W-1:0]   in_style_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [clr_pkg::COORD_W-1:0]   out_cell_x,
  output logic [clr_pkg::COORD_W-1:0]   out_cell_y,
  output logic                          out_visible,
  output logic [clr_pkg::GLYPH_W-1:0]   out_glyph,
  output logic [clr_pkg::STYLE_W-1:0]   out_style_out,
  output logic                          out_last_cell,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [clr_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [clr_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [clr_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import clr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_WALK
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CLIP_W-1:0]        clip_w_r, clip_w_nxt;
  logic [CLIP_W-1:0]        clip_h_r, clip_h_nxt;

  logic [COORD_W-1:0]       x_r, x_nxt;
  logic [COORD_W-1:0]       y_r, y_nxt;
  logic [COORD_W-1:0]       xe_r, xe_nxt;
  logic [COORD_W-1:0]       ye_r, ye_nxt;
  logic [COORD_W-1:0]       dx_r, dx_nxt;
  logic [COORD_W-1:0]       dy_r, dy_nxt;
  logic                     sx_pos_r, sx_pos_nxt;
  logic                     sy_pos_r, sy_pos_nxt;
  logic [STYLE_W-1:0]       style_r, style_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]       out_x_r, out_x_nxt;
  logic [COORD_W-1:0]       out_y_r, out_y_nxt;
  logic                     out_vis_r, out_vis_nxt;
  logic [GLYPH_W-1:0]       out_glyph_r, out_glyph_nxt;
  logic [STYLE_W-1:0]       out_style_r, out_style_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     in_fire;
  logic                     cfg_wr;
  logic                     step_en;
  logic                     done;
  logic signed [ERR_W:0]    e2;
  logic signed [ERR_W:0]    neg_dy;
  logic signed [ERR_W:0]    pos_dx;
  logic                     mx;
  logic                     my;
  logic [COORD_W-1:0]       sx_a, sx_b, sy_a, sy_b;
  logic signed [ERR_W-1:0]  add_base;
  logic signed [ERR_W-1:0]  add_p;
  logic signed [ERR_W-1:0]  add_n;
  logic signed [ERR_W-1:0]  add_sum;
  logic [GLYPH_W-1:0]       glyph;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      REG_CLIP_WIDTH:  cfg_prdata = {{(PDATA_W-CLIP_W){1'b0}}, clip_w_r};
      REG_CLIP_HEIGHT: cfg_prdata = {{(PDATA_W-CLIP_W){1'b0}}, clip_h_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Error test for the current cell
  assign e2     = {err_r, 1'b0};
  assign neg_dy = -$signed({{(ERR_W+1-COORD_W){1'b0}}, dy_r});
  assign pos_dx = $signed({{(ERR_W+1-COORD_W){1'b0}}, dx_r});
  assign mx     = e2 > neg_dy;
  assign my     = e2 < pos_dx;
  assign done   = (x_r == xe_r) && (y_r == ye_r);

  always_comb begin
    if (mx && my) begin
      glyph = (sx_pos_r == sy_pos_r) ? GLYPH_BACK : GLYPH_SLASH;
    end else if (mx) begin
      glyph = GLYPH_DASH;
    end else begin
      glyph = GLYPH_BAR;
    end
  end

  // Shared error adder: dx - dy at setup, err + dx/- dy while walking
  always_comb begin
    add_base = (state_r == S_SETUP) ? '0 : err_r;
    add_p    = ((state_r == S_SETUP) || my) ?
               $signed({{(ERR_W-COORD_W){1'b0}}, dx_r}) : '0;
    add_n    = ((state_r == S_SETUP) || mx) ?
               $signed({{(ERR_W-COORD_W){1'b0}}, dy_r}) : '0;
    add_sum  = add_base + add_p - add_n;
  end

  assign step_en = (state_r == S_WALK) && (!out_valid_r || out_ready);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    clip_w_nxt    = clip_w_r;
    clip_h_nxt    = clip_h_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    xe_nxt        = xe_r;
    ye_nxt        = ye_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sx_pos_nxt    = sx_pos_r;
    sy_pos_nxt    = sy_pos_r;
    style_nxt     = style_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_vis_nxt   = out_vis_r;
    out_glyph_nxt = out_glyph_r;
    out_style_nxt = out_style_r;
    out_last_nxt  = out_last_r;
    sx_a = sat_coord(in_start_x);
    sx_b = sat_coord(in_end_x);
    sy_a = sat_coord(in_start_y);
    sy_b = sat_coord(in_end_y);

    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_CLIP_WIDTH:  clip_w_nxt = cfg_pwdata[CLIP_W-1:0];
        REG_CLIP_HEIGHT: clip_h_nxt = cfg_pwdata[CLIP_W-1:0];
        default:         clip_w_nxt = clip_w_r;
      endcase
    end

    // Drop the output item once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_nxt      = sx_a;
          y_nxt      = sy_a;
          xe_nxt     = sx_b;
          ye_nxt     = sy_b;
          dx_nxt     = abs_diff(sx_a, sx_b);
          dy_nxt     = abs_diff(sy_a, sy_b);
          sx_pos_nxt = sx_a < sx_b;
          sy_pos_nxt = sy_a < sy_b;
          style_nxt  = in_style_tag;
          state_nxt  = S_SETUP;
        end
      end
      S_SETUP: begin
        err_nxt   = add_sum;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // Emit the current cell and advance
        if (step_en) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = x_r;
          out_y_nxt     = y_r;
          out_vis_nxt   = ({1'b0, x_r} < clip_w_r) && ({1'b0, y_r} < clip_h_r);
          out_glyph_nxt = glyph;
          out_style_nxt = style_r;
          out_last_nxt  = done;
          if (done) begin
            state_nxt = S_IDLE;
          end else begin
            err_nxt = add_sum;
            if (mx) begin
              x_nxt = sx_pos_r ? x_r + 1'b1 : x_r - 1'b1;
            end
            if (my) begin
              y_nxt = sy_pos_r ? y_r + 1'b1 : y_r - 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, registers and output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      clip_w_r    <= CLIP_RESET;
      clip_h_r    <= CLIP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clip_w_r    <= clip_w_nxt;
      clip_h_r    <= clip_h_nxt;
    end
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    xe_r        <= xe_nxt;
    ye_r        <= ye_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    sx_pos_r    <= sx_pos_nxt;
    sy_pos_r    <= sy_pos_nxt;
    style_r     <= style_nxt;
    err_r       <= err_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_vis_r   <= out_vis_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_style_r <= out_style_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_cell_x    = out_x_r;
  assign out_cell_y    = out_y_r;
  assign out_visible   = out_vis_r;
  assign out_glyph     = out_glyph_r;
  assign out_style_out = out_style_r;
  assign out_last_cell = out_last_r;

`include "clipped_line_rasterizer_assert.svh"

  `CLR_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "ready high after accept")
  `CLR_ASSERT_NEXT(a_end_cell_last, step_en && done, out_valid && out_last_cell && in_ready, "end cell not flagged last")
  `CLR_ASSERT_NEXT(a_mid_cell_not_last, step_en && !done, out_valid && !out_last_cell && !in_ready, "early last flag")

endmodule
